[sv/epaper_ghost_debt_refresh_policy_top_defines.svh]
// Assertion macros shared by the refresh policy RTL.
`ifndef EPAPER_GHOST_DEBT_REFRESH_POLICY_TOP_DEFINES_SVH
`define EPAPER_GHOST_DEBT_REFRESH_POLICY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Consequence must hold in the cycle after the antecedent.
`define EGDRP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
// Consequence must hold in the same cycle as the antecedent.
`define EGDRP_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define EGDRP_ASSERT_NEXT(lbl, ante, cons)
`define EGDRP_ASSERT_SAME(lbl, ante, cons)
`endif

`endif

[sv/egdrp_pkg.sv]
// Types and constants of the refresh policy block.
`timescale 1ns / 1ps
`default_nettype none
package egdrp_pkg;

	localparam int NUM_SLOTS = 5;
	localparam int SLOT_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 16;
	localparam int CNT_W     = 8;
	localparam int STAT_W    = 16;

	// Refresh kinds
	localparam logic [1:0] KIND_FASTEST = 2'd0;
	localparam logic [1:0] KIND_TEXT    = 2'd1;
	localparam logic [1:0] KIND_FAST    = 2'd2;
	localparam logic [1:0] KIND_QUALITY = 2'd3;

	localparam logic [2:0] REGION_STATUS = 3'd3;

	// Operation carried in the input tuser
	localparam logic MODE_RESOLVE = 1'b0;
	localparam logic MODE_RECORD  = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FASTEST_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_LIMIT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_LIMIT    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_LIMIT  = 2'd3;

	localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hFF;
	localparam logic [STAT_W-1:0] STAT_MAX = 16'hFFFF;

	typedef struct packed {
		logic load;  // capture the accepted input item
		logic exec;  // apply the item and load the output register
	} cmd_t;

	typedef struct packed {
		logic       mode;
		logic [1:0] refresh_kind;
		logic [2:0] region;
		logic       upgrade_ok;
	} item_t;

	// Debt slot of each screen region; control and full share slot 0,
	// rtc and rtc+key share slot 1. Status maps to 0 but is never used.
	function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] region);
		logic [SLOT_W-1:0] s;
		case (region)
			3'd0: s = 3'd0;
			3'd1: s = 3'd1;
			3'd2: s = 3'd1;
			3'd3: s = 3'd0;
			3'd4: s = 3'd2;
			3'd5: s = 3'd3;
			3'd6: s = 3'd4;
			3'd7: s = 3'd0;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[sv/egdrp_ctrl.sv]
// Controller: item handshake and output register valid.
`timescale 1ns / 1ps
`default_nettype none
`include "epaper_ghost_debt_refresh_policy_top_defines.svh"
module egdrp_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output egdrp_pkg::cmd_t    cmd
);
	import egdrp_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WORK = 2'b10
	} state_t;

	state_t state_q;
	logic   out_vld_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign out_free = !out_vld_q || m_tready;

	always_comb begin
		cmd.load = s_tvalid && s_tready;
		cmd.exec = (state_q == ST_WORK) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					if (cmd.exec) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.exec) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	`EGDRP_ASSERT_NEXT(a_exec_shows_result, cmd.exec, m_tvalid)
	`EGDRP_ASSERT_NEXT(a_load_blocks_input, cmd.load, state_q == ST_WORK && !s_tready)
	`EGDRP_ASSERT_NEXT(a_work_holds_on_stall,
		state_q == ST_WORK && out_vld_q && !m_tready, state_q == ST_WORK)

endmodule
`default_nettype wire

[sv/egdrp_dp.sv]
// Datapath: limits, debt counters, resolve and record logic, output register.
`timescale 1ns / 1ps
`default_nettype none
`include "epaper_ghost_debt_refresh_policy_top_defines.svh"
module egdrp_dp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire egdrp_pkg::cmd_t                  cmd,
	input  wire egdrp_pkg::item_t                 item,
	input  wire logic                             cfg_we,
	input  wire logic [egdrp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [egdrp_pkg::CFG_W-1:0]      cfg_data,
	output logic [1:0]                            chosen_kind,
	output logic                                  cleanup_pending
);
	import egdrp_pkg::*;

	logic [CNT_W-1:0]  fastest_lim_q, fast_lim_q, text_lim_q;
	logic [STAT_W-1:0] status_lim_q;

	logic [CNT_W-1:0]  fastest_q [NUM_SLOTS];
	logic [CNT_W-1:0]  fast_q    [NUM_SLOTS];
	logic [CNT_W-1:0]  text_q    [NUM_SLOTS];
	logic [STAT_W-1:0] status_q;
	logic              pending_q;

	item_t             item_q;
	logic [1:0]        kind_q;
	logic              pend_out_q;

	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0]  fastest_cur, fast_cur, text_cur;
	logic              fastest_hit, fast_hit, text_hit;
	logic [1:0]        resolved;
	logic [STAT_W-1:0] status_inc;
	logic              is_status, is_record, pending_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fastest_lim_q <= 8'd4;
			fast_lim_q    <= 8'd4;
			text_lim_q    <= 8'd8;
			status_lim_q  <= 16'd16;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_FASTEST_LIMIT: fastest_lim_q <= cfg_data[CNT_W-1:0];
				REG_FAST_LIMIT:    fast_lim_q    <= cfg_data[CNT_W-1:0];
				REG_TEXT_LIMIT:    text_lim_q    <= cfg_data[CNT_W-1:0];
				REG_STATUS_LIMIT:  status_lim_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
	end

	assign slot        = slot_of(item_q.region);
	assign fastest_cur = fastest_q[slot];
	assign fast_cur    = fast_q[slot];
	assign text_cur    = text_q[slot];
	assign is_status   = (item_q.region == REGION_STATUS);
	assign is_record   = (item_q.mode == MODE_RECORD);

	assign fastest_hit = ({1'b0, fastest_cur} + 9'd1) >= {1'b0, fastest_lim_q};
	assign fast_hit    = ({1'b0, fast_cur} + 9'd1) >= {1'b0, fast_lim_q};
	assign text_hit    = ({1'b0, text_cur} + 9'd1) >= {1'b0, text_lim_q};

	always_comb begin
		resolved = item_q.refresh_kind;
		if (item_q.refresh_kind != KIND_QUALITY && !is_status && item_q.upgrade_ok) begin
			case (item_q.refresh_kind)
				KIND_FASTEST: begin
					if (fastest_hit) begin
						resolved = fast_hit ? KIND_QUALITY : KIND_FAST;
					end
				end
				KIND_FAST: begin
					if (fast_hit) begin
						resolved = KIND_QUALITY;
					end
				end
				KIND_TEXT: begin
					if (text_hit) begin
						resolved = KIND_QUALITY;
					end
				end
				default: ;
			endcase
		end
	end

	assign status_inc = (status_q < STAT_MAX) ? status_q + 16'd1 : status_q;

	always_comb begin
		pending_nxt = pending_q;
		if (is_record) begin
			if (item_q.refresh_kind == KIND_QUALITY) begin
				pending_nxt = 1'b0;
			end else if (is_status && status_inc >= status_lim_q) begin
				pending_nxt = 1'b1;
			end
		end
	end

	// Debt state: only record items change it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				fastest_q[i] <= '0;
				fast_q[i]    <= '0;
				text_q[i]    <= '0;
			end
			status_q  <= '0;
			pending_q <= 1'b0;
		end else if (cmd.exec && is_record) begin
			pending_q <= pending_nxt;
			if (item_q.refresh_kind == KIND_QUALITY) begin
				for (int i = 0; i < NUM_SLOTS; i++) begin
					fastest_q[i] <= '0;
					fast_q[i]    <= '0;
					text_q[i]    <= '0;
				end
				status_q <= '0;
			end else if (is_status) begin
				status_q <= status_inc;
			end else begin
				case (item_q.refresh_kind)
					KIND_FASTEST: begin
						if (fastest_cur < fastest_lim_q) begin
							fastest_q[slot] <= fastest_cur + 8'd1;
						end
					end
					KIND_FAST: begin
						fastest_q[slot] <= '0;
						if (fast_cur < fast_lim_q) begin
							fast_q[slot] <= fast_cur + 8'd1;
						end
					end
					KIND_TEXT: begin
						if (text_cur < CNT_MAX) begin
							text_q[slot] <= text_cur + 8'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			kind_q     <= is_record ? item_q.refresh_kind : resolved;
			pend_out_q <= pending_nxt;
		end
	end

	assign chosen_kind     = kind_q;
	assign cleanup_pending = pend_out_q;

	`EGDRP_ASSERT_NEXT(a_quality_clears,
		cmd.exec && is_record && item_q.refresh_kind == KIND_QUALITY,
		!pending_q && status_q == '0)
	`EGDRP_ASSERT_SAME(a_pending_has_debt, pending_q, status_q != '0)

endmodule
`default_nettype wire

[sv/epaper_ghost_debt_refresh_policy_top.sv]
// Top level of the e-paper ghosting debt refresh policy block.
// Use: each input item is either a resolve request or a record of a finished
// refresh. The slave stream carries the item: s_tuser is the operation
// (0 resolve, 1 record), s_tdata holds refresh kind, region and the
// cleanup-allowed flag. Every item returns exactly one result on the master
// stream: the kind to use (or the recorded kind echoed) and the cleanup
// pending flag as it stands after the item.
// Flow: an accepted item is captured in the controller's idle state and
// applied in the work state, which loads its result into the output register;
// one item is in flight at a time, so no new item is taken before the last one is applied.
// Stall: the result waits in the output register; a new item is still taken
// while it waits, and its work step holds until the old result is taken.
// Reset: limits return to 4, 4, 8 and 16, all debt counters and the pending flag clear, no result is valid.
// The user must write limits through cfg_we, cfg_idx and cfg_data only while the block is idle;
// the block itself does not enforce this. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module epaper_ghost_debt_refresh_policy_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,  // refresh_kind[1:0], region[4:2], upgrade_ok[5], zero
	input  wire logic                             s_tuser,  // mode[0]
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [7:0]                            m_tdata,  // chosen_kind[1:0], cleanup_pending[2], zero
	input  wire logic                             cfg_we,
	input  wire logic [egdrp_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [egdrp_pkg::CFG_W-1:0]      cfg_data
);
	import egdrp_pkg::*;

	cmd_t       cmd;
	item_t      item;
	logic [1:0] chosen_kind;
	logic       cleanup_pending;

	// Unpack the incoming item.
	always_comb begin
		item.mode          = s_tuser;
		item.refresh_kind  = s_tdata[1:0];
		item.region        = s_tdata[4:2];
		item.upgrade_ok    = s_tdata[5];
	end

	egdrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	egdrp_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.item            (item),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.chosen_kind     (chosen_kind),
		.cleanup_pending (cleanup_pending)
	);

	// Pack the result, zero fill to a whole byte.
	assign m_tdata = {5'd0, cleanup_pending, chosen_kind};

endmodule
`default_nettype wire
